[src/mtfal_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// mtfal_pkg
// Shared types, constants and helpers for the max tree first-at-least unit.
// ----------------------------------------------------------------------------
package mtfal_pkg;

    localparam int NUM_ELEMENTS = 1024;
    localparam int NODE_COUNT   = 2 * NUM_ELEMENTS;
    localparam int NODE_AW      = $clog2(NODE_COUNT);
    localparam int IDX_W        = 10;
    localparam int VAL_W        = 32;
    localparam int SIZE_W       = 11;
    localparam int PADDR_W      = 3;
    localparam int PDATA_W      = 32;
    localparam int S_TDATA_W    = 48;
    localparam int M_TDATA_W    = 16;

    localparam logic [SIZE_W-1:0]  SIZE_RESET   = SIZE_W'(1024);
    localparam logic [PADDR_W-1:0] ADDR_SIZE    = PADDR_W'(0);

    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_WR_LEAF,
        S_WR_UP,
        S_Q_ROOT,
        S_Q_DOWN,
        S_Q_OUT
    } t_state;

    function automatic logic ge_signed(input logic [VAL_W-1:0] a,
                                       input logic [VAL_W-1:0] b);
        ge_signed = ($signed(a) >= $signed(b));
    endfunction

endpackage
`default_nettype wire

[src/mtfal_ram.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// mtfal_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module mtfal_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 2048
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule
`default_nettype wire

[src/max_tree_first_at_least_unit.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// max_tree_first_at_least_unit
// Binary max tree over 1024 signed 32-bit elements in one node RAM, one level a cycle.
// Write: accept, leaf write, 10 parent updates; an out-of-range write is dropped. Query:
// accept, root check, 10 descents, output to the result register; only accept, root
// check and output when the root maximum is below the threshold; the output step holds
// while the previous result waits. One transaction at a time; reset clears 2048 nodes.
// ----------------------------------------------------------------------------
module max_tree_first_at_least_unit (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    // input stream
    input  wire logic                               i_s_tvalid,
    output logic                                    o_s_tready,
    // [9:0] element_index, [41:10] operand_value, [47:42] zero
    input  wire logic [mtfal_pkg::S_TDATA_W-1:0]    i_s_tdata,
    // [0] operation
    input  wire logic                               i_s_tuser,
    // result stream
    output logic                                    o_m_tvalid,
    input  wire logic                               i_m_tready,
    // [9:0] first_index, [15:10] zero
    output logic      [mtfal_pkg::M_TDATA_W-1:0]    o_m_tdata,
    // [0] found
    output logic                                    o_m_tuser,
    // configuration
    input  wire logic                               i_psel,
    input  wire logic                               i_penable,
    input  wire logic                               i_pwrite,
    input  wire logic [mtfal_pkg::PADDR_W-1:0]      i_paddr,
    input  wire logic [mtfal_pkg::PDATA_W-1:0]      i_pwdata,
    output logic      [mtfal_pkg::PDATA_W-1:0]      o_prdata,
    output logic                                    o_pready
);

    import mtfal_pkg::*;

    localparam logic [NODE_AW-1:0] ROOT_NODE = NODE_AW'(1);
    localparam logic [NODE_AW-1:0] LEAF_BASE = NODE_AW'(NUM_ELEMENTS);
    localparam logic [NODE_AW-1:0] LAST_NODE = NODE_AW'(NODE_COUNT - 1);

    t_state               r_state, n_state;
    logic [NODE_AW-1:0]   r_node,  n_node;
    logic [NODE_AW-1:0]   r_clr,   n_clr;
    logic [VAL_W-1:0]     r_val,   n_val;
    logic                 r_rfound, n_rfound;
    logic [IDX_W-1:0]     r_ridx,  n_ridx;
    logic                 r_mv,    n_mv;
    logic                 r_mfound, n_mfound;
    logic [IDX_W-1:0]     r_midx,  n_midx;
    logic [SIZE_W-1:0]    r_size;

    logic                 ram_we;
    logic [NODE_AW-1:0]   ram_waddr;
    logic [VAL_W-1:0]     ram_wdata;
    logic [NODE_AW-1:0]   ram_raddr;
    logic [VAL_W-1:0]     ram_rdata;

    logic                 s_fire;
    logic                 cfg_wr;
    logic [IDX_W-1:0]     in_idx;
    logic [VAL_W-1:0]     in_val;
    logic [NODE_AW-1:0]   parent;
    logic [NODE_AW-1:0]   left;
    logic [NODE_AW-1:0]   child;
    logic [VAL_W-1:0]     up_max;
    logic                 leaf_found;

    mtfal_ram #(
        .WIDTH (VAL_W),
        .DEPTH (NODE_COUNT)
    ) u_node_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign o_s_tready = (r_state == S_IDLE);
    assign s_fire     = i_s_tvalid && o_s_tready;
    assign in_idx     = i_s_tdata[IDX_W-1:0];
    assign in_val     = i_s_tdata[IDX_W +: VAL_W];

    assign cfg_wr     = i_psel && i_penable && i_pwrite && o_pready;
    assign o_pready   = 1'b1;
    assign o_prdata   = PDATA_W'(r_size);

    assign o_m_tvalid = r_mv;
    assign o_m_tuser  = r_mfound;
    assign o_m_tdata  = M_TDATA_W'(r_midx);

    assign parent     = r_node >> 1;
    assign left       = r_node << 1;
    assign child      = ge_signed(ram_rdata, r_val) ? left : (left | NODE_AW'(1));
    assign up_max     = ge_signed(r_val, ram_rdata) ? r_val : ram_rdata;
    assign leaf_found = ({1'b0, child[IDX_W-1:0]} < r_size);

    always_comb begin
        n_state   = r_state;
        n_node    = r_node;
        n_clr     = r_clr;
        n_val     = r_val;
        n_rfound  = r_rfound;
        n_ridx    = r_ridx;
        n_mv      = r_mv && !i_m_tready;
        n_mfound  = r_mfound;
        n_midx    = r_midx;
        ram_we    = 1'b0;
        ram_waddr = r_node;
        ram_wdata = r_val;
        ram_raddr = r_node ^ NODE_AW'(1);
        case (r_state)
            S_CLEAR: begin
                ram_we    = 1'b1;
                ram_waddr = r_clr;
                ram_wdata = '0;
                n_clr     = r_clr + NODE_AW'(1);
                if (r_clr == LAST_NODE) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                ram_raddr = ROOT_NODE;
                if (s_fire) begin
                    n_val = in_val;
                    if (i_s_tuser == OP_QUERY) begin
                        n_state = S_Q_ROOT;
                    end else if ({1'b0, in_idx} < r_size) begin
                        n_node  = LEAF_BASE | NODE_AW'(in_idx);
                        n_state = S_WR_LEAF;
                    end
                end
            end
            S_WR_LEAF: begin
                ram_we  = 1'b1;
                n_state = S_WR_UP;
            end
            S_WR_UP: begin
                ram_we    = 1'b1;
                ram_waddr = parent;
                ram_wdata = up_max;
                ram_raddr = parent ^ NODE_AW'(1);
                n_val     = up_max;
                n_node    = parent;
                if (parent == ROOT_NODE) begin
                    n_state = S_IDLE;
                end
            end
            S_Q_ROOT: begin
                if (!ge_signed(ram_rdata, r_val)) begin
                    n_rfound = 1'b0;
                    n_ridx   = '0;
                    n_state  = S_Q_OUT;
                end else begin
                    n_node    = ROOT_NODE;
                    ram_raddr = ROOT_NODE << 1;
                    n_state   = S_Q_DOWN;
                end
            end
            S_Q_DOWN: begin
                ram_raddr = child << 1;
                if (child >= LEAF_BASE) begin
                    n_rfound = leaf_found;
                    n_ridx   = leaf_found ? child[IDX_W-1:0] : '0;
                    n_state  = S_Q_OUT;
                end else begin
                    n_node = child;
                end
            end
            S_Q_OUT: begin
                if (!r_mv || i_m_tready) begin
                    n_mv     = 1'b1;
                    n_mfound = r_rfound;
                    n_midx   = r_ridx;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_clr   <= '0;
            r_mv    <= 1'b0;
            r_size  <= SIZE_RESET;
        end else begin
            r_state <= n_state;
            r_clr   <= n_clr;
            r_mv    <= n_mv;
            if (cfg_wr && i_paddr == ADDR_SIZE) begin
                r_size <= i_pwdata[SIZE_W-1:0];
            end
        end
        r_node   <= n_node;
        r_val    <= n_val;
        r_rfound <= n_rfound;
        r_ridx   <= n_ridx;
        r_mfound <= n_mfound;
        r_midx   <= n_midx;
    end

    // a not-found result carries index zero
    a_nf_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !o_m_tuser) |-> (o_m_tdata == '0))
        else $error("not-found result with nonzero index");

    // a reported index lies inside the elements in use
    a_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tuser) |-> ({1'b0, o_m_tdata[IDX_W-1:0]} < r_size))
        else $error("reported index outside size in use");

    // no transaction taken while the node RAM is being cleared
    a_clr_block: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CLEAR) |-> !o_s_tready)
        else $error("input accepted during clearing pass");

    // tree updates never touch the unused node zero
    a_no_node0: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (ram_we && r_state != S_CLEAR) |-> (ram_waddr != '0))
        else $error("tree update wrote node zero");

endmodule
`default_nettype wire

[verif/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the max tree first-at-least unit. Writes and
// queries go in on the input stream; each query answer is checked against a
// given answer for known directed rows, else a leaf-array predictor that scans
// for the lowest index at or above the threshold. The size register is changed
// between drained phases, covering zero, one, the capacity and values above it.
// ----------------------------------------------------------------------------
module testbench;
    import mtfal_pkg::*;

    typedef struct packed {
        logic              found;
        logic [IDX_W-1:0]  first_index;
    } t_answer;

    typedef struct packed {
        logic              op;
        logic [IDX_W-1:0]  idx;
        logic [VAL_W-1:0]  val;
        logic              known;
        t_answer           ans;
    } t_stim_row;

    localparam int SETTLE_CYCLES = 32;
    localparam int HOLD_CYCLES   = 400;
    localparam int PHASES        = 8;
    localparam int PHASE_ITEMS   = 235;

    logic                   clk       = 1'b0;
    logic                   rst_n     = 1'b0;
    logic                   s_tvalid  = 1'b0;
    logic [S_TDATA_W-1:0]   s_tdata   = '0;
    logic                   s_tuser   = 1'b0;
    logic                   m_tready  = 1'b0;
    logic                   psel      = 1'b0;
    logic                   penable   = 1'b0;
    logic                   pwrite    = 1'b0;
    logic [PADDR_W-1:0]     paddr     = '0;
    logic [PDATA_W-1:0]     pwdata    = '0;

    wire                    o_s_tready;
    wire                    o_m_tvalid;
    wire  [M_TDATA_W-1:0]   o_m_tdata;
    wire                    o_m_tuser;
    wire  [PDATA_W-1:0]     o_prdata;
    wire                    o_pready;

    logic signed [VAL_W-1:0] tree_leaf [NUM_ELEMENTS];
    int                      live_size = NUM_ELEMENTS;
    t_answer                 pending_answers [$];
    t_stim_row               directed_rows [$];
    int                      n_errors     = 0;
    bit                      no_idle      = 1'b0;
    bit                      hold_request = 1'b0;

    max_tree_first_at_least_unit u_dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (s_tdata),
        .i_s_tuser  (s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser),
        .i_psel     (psel),
        .i_penable  (penable),
        .i_pwrite   (pwrite),
        .i_paddr    (paddr),
        .i_pwdata   (pwdata),
        .o_prdata   (o_prdata),
        .o_pready   (o_pready)
    );

    initial begin
        forever #1 clk = ~clk;
    end

    initial begin
        #1_000_000;
        $display("** max_tree_first_at_least_unit: FAILED **");
        $finish;
    end

    task automatic report_mismatch(input string what, input longint got, input longint want);
        if (n_errors < 100) begin
            $display("mismatch at %0t: %s got %0h expected %0h", $time, what, got, want);
        end
        n_errors++;
    endtask

    function automatic t_answer first_at_least(input logic signed [VAL_W-1:0] threshold);
        t_answer a;
        a = '0;
        for (int k = 0; k < live_size; k++) begin
            if (tree_leaf[k] >= threshold) begin
                a.found       = 1'b1;
                a.first_index = IDX_W'(k);
                break;
            end
        end
        return a;
    endfunction

    function automatic logic [VAL_W-1:0] pick_value();
        int kind;
        kind = $urandom_range(9);
        case (kind)
            0: begin
                case ($urandom_range(3))
                    0: return 32'h8000_0000;
                    1: return 32'h7FFF_FFFF;
                    2: return 32'h0000_0000;
                    default: return 32'hFFFF_FFFF;
                endcase
            end
            1, 2, 3, 4: return VAL_W'($signed($urandom_range(31)) - 16);
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [VAL_W-1:0] pick_threshold();
        int kind;
        logic [VAL_W-1:0] base;
        kind = $urandom_range(9);
        if (kind >= 1 && kind <= 4 && live_size > 0) begin
            base = tree_leaf[$urandom_range(live_size - 1)];
            return base + VAL_W'($signed($urandom_range(2)) - 1);
        end
        return pick_value();
    endfunction

    task automatic row(input logic op, input int idx, input logic [VAL_W-1:0] val,
                       input logic known, input logic found, input int first_index);
        t_stim_row r;
        r.op              = op;
        r.idx             = IDX_W'(idx);
        r.val             = val;
        r.known           = known;
        r.ans.found       = found;
        r.ans.first_index = IDX_W'(first_index);
        directed_rows.push_back(r);
    endtask

    task automatic send_item(input t_stim_row r);
        s_tvalid <= 1'b1;
        s_tuser  <= r.op;
        s_tdata  <= S_TDATA_W'({r.val, r.idx});
        do @(posedge clk); while (!o_s_tready);
        if (r.op == OP_QUERY) begin
            pending_answers.push_back(r.known ? r.ans : first_at_least(r.val));
        end else if (int'(r.idx) < live_size) begin
            tree_leaf[r.idx] = r.val;
        end
    endtask

    task automatic drain(input int settle);
        s_tvalid <= 1'b0;
        do @(posedge clk); while (pending_answers.size() != 0);
        repeat (settle) @(posedge clk);
    endtask

    task automatic set_size(input logic [SIZE_W-1:0] size);
        logic [PDATA_W-1:0] readback;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_SIZE;
        pwdata  <= PDATA_W'(size);
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!o_pready);
        pwrite  <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!o_pready);
        readback = o_prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        if (readback !== PDATA_W'(size)) begin
            report_mismatch("size readback", readback, size);
        end
        live_size = (size > NUM_ELEMENTS) ? NUM_ELEMENTS : int'(size);
    endtask

    // result side: check each transaction, stall at random, hold off on request
    initial begin : result_side
        int      hold_left;
        t_answer want;
        hold_left = 0;
        forever begin
            @(posedge clk);
            if (rst_n && o_m_tvalid && m_tready) begin
                if (pending_answers.size() == 0) begin
                    report_mismatch("unexpected result", o_m_tdata, 0);
                end else begin
                    want = pending_answers.pop_front();
                    if (o_m_tuser !== want.found) begin
                        report_mismatch("found", o_m_tuser, want.found);
                    end
                    if (o_m_tdata[IDX_W-1:0] !== want.first_index) begin
                        report_mismatch("first_index", o_m_tdata[IDX_W-1:0], want.first_index);
                    end
                end
            end
            if (hold_request) begin
                hold_request = 1'b0;
                hold_left    = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else if (no_idle) begin
                m_tready <= 1'b1;
            end else begin
                m_tready <= ($urandom_range(99) >= 30);
            end
        end
    end

    initial begin : input_side
        logic [SIZE_W-1:0] phase_size [PHASES];
        t_stim_row         r;

        foreach (tree_leaf[k]) tree_leaf[k] = '0;

        // the reset clearing pass zeroes the contents, so the first answers are known
        row(OP_QUERY, 0,     32'h0000_0000, 1, 1, 0);
        row(OP_QUERY, 0,     32'h0000_0001, 1, 0, 0);
        row(OP_QUERY, 0,     32'h8000_0000, 1, 1, 0);
        row(OP_QUERY, 0,     32'h7FFF_FFFF, 1, 0, 0);
        row(OP_WRITE, 1023,  32'h7FFF_FFFF, 0, 0, 0);
        row(OP_QUERY, 0,     32'h7FFF_FFFF, 1, 1, 1023);
        row(OP_WRITE, 0,     32'h8000_0000, 0, 0, 0);
        row(OP_QUERY, 0,     32'h0000_0000, 1, 1, 1);
        row(OP_QUERY, 1023,  32'h8000_0000, 1, 1, 0);
        row(OP_WRITE, 'h155, 32'h5555_5555, 0, 0, 0);
        row(OP_WRITE, 'h2AA, 32'hAAAA_AAAA, 0, 0, 0);
        row(OP_QUERY, 'h2AA, 32'h5555_5555, 0, 0, 0);
        row(OP_QUERY, 'h155, 32'h5555_5556, 0, 0, 0);
        row(OP_WRITE, 1,     32'hFFFF_FFFF, 0, 0, 0);
        row(OP_QUERY, 0,     32'h0000_0000, 0, 0, 0);
        row(OP_QUERY, 0,     32'hFFFF_FFFF, 0, 0, 0);
        row(OP_WRITE, 1023,  32'h0000_0000, 0, 0, 0);
        row(OP_QUERY, 0,     32'h0000_0001, 0, 0, 0);
        row(OP_WRITE, 'h155, 32'h0000_0000, 0, 0, 0);
        row(OP_QUERY, 0,     32'h0000_0001, 0, 0, 0);
        row(OP_WRITE, 512,   32'h0000_0001, 0, 0, 0);
        row(OP_QUERY, 0,     32'h0000_0001, 0, 0, 0);
        row(OP_QUERY, 0,     32'hAAAA_AAAA, 0, 0, 0);

        phase_size = '{11'd1024, 11'd1, 11'd2047, 11'd0, 11'd2,
                       SIZE_W'($urandom_range(3, 1023)), 11'd1024,
                       SIZE_W'($urandom_range(2047))};

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        foreach (directed_rows[k]) begin
            send_item(directed_rows[k]);
        end

        for (int p = 0; p < PHASES; p++) begin
            drain(SETTLE_CYCLES);
            set_size(phase_size[p]);
            no_idle = (p == 6);
            for (int k = 0; k < PHASE_ITEMS; k++) begin
                if (p == 0 && k == 100) hold_request = 1'b1;
                if (p == 1 && k == 120) drain(0);
                r       = '0;
                r.op    = ($urandom_range(99) < 45) ? OP_QUERY : OP_WRITE;
                if (r.op == OP_WRITE && live_size > 0 && $urandom_range(9) < 8) begin
                    r.idx = IDX_W'($urandom_range(live_size - 1));
                end else begin
                    r.idx = IDX_W'($urandom_range(NUM_ELEMENTS - 1));
                end
                r.val   = (r.op == OP_QUERY) ? pick_threshold() : pick_value();
                if (!no_idle && $urandom_range(99) < 30) begin
                    s_tvalid <= 1'b0;
                    repeat ($urandom_range(1, 3)) @(posedge clk);
                end
                send_item(r);
            end
        end
        no_idle = 1'b0;

        drain(SETTLE_CYCLES);
        if (n_errors == 0) begin
            $display("** max_tree_first_at_least_unit: PASSED **");
        end else begin
            $display("** max_tree_first_at_least_unit: FAILED **");
        end
        $finish;
    end

endmodule

[files.f]
src/mtfal_pkg.sv
src/mtfal_ram.sv
src/max_tree_first_at_least_unit.sv
verif/testbench.sv
